/* rtl/core/lu8d_pkg.sv */
// Shared types, byte-class constants and the segment decode function for the
// lenient UTF-8 decoder. No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lu8d_pkg;

    localparam int unsigned QUEUE_BYTES = 4;
    localparam int unsigned QUEUE_W     = 8 * QUEUE_BYTES;
    localparam int unsigned CP_W        = 21;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_E0     = 8'hE0;
    localparam logic [7:0] MASK_F0     = 8'hF0;
    localparam logic [7:0] LEAD_TWO    = 8'hC0;
    localparam logic [7:0] LEAD_THREE  = 8'hE0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_MARK   = 8'h80;
    localparam logic [7:0] BITS_TWO    = 8'h1F;
    localparam logic [7:0] BITS_THREE  = 8'h0F;
    localparam logic [7:0] BITS_FOUR   = 8'h07;
    localparam logic [7:0] BITS_CONT   = 8'h3F;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      len;
        logic            broken;
        logic            waiting;
    } seg_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic waiting;
        logic last;
    } status_t;

    // Decodes the sequence that starts at the lowest byte of q, cnt bytes valid.
    function automatic seg_t seg_eval(input logic [QUEUE_W-1:0] q,
                                      input logic [2:0] cnt,
                                      input logic eot);
        logic [7:0]      lead;
        logic [7:0]      cont;
        logic [2:0]      need;
        logic [CP_W-1:0] cp;
        logic            stop;
        seg_t            r;
        lead      = q[7:0];
        r.broken  = 1'b0;
        r.waiting = 1'b0;
        stop      = 1'b0;
        if (lead < ASCII_LIMIT) begin
            need = 3'd1;
            cp   = {13'd0, lead};
        end else if ((lead & MASK_E0) == LEAD_TWO) begin
            need = 3'd2;
            cp   = {13'd0, lead & BITS_TWO};
        end else if ((lead & MASK_F0) == LEAD_THREE) begin
            need = 3'd3;
            cp   = {13'd0, lead & BITS_THREE};
        end else begin
            need = 3'd4;
            cp   = {13'd0, lead & BITS_FOUR};
        end
        for (int i = 1; i < QUEUE_BYTES; i++) begin
            cont = q[8*i +: 8];
            if (!stop && (3'(i) < need)) begin
                if (3'(i) >= cnt) begin
                    if (eot) begin
                        r.broken = 1'b1;
                    end else begin
                        r.waiting = 1'b1;
                    end
                    stop = 1'b1;
                end else if ((cont & CONT_MASK) != CONT_MARK) begin
                    r.broken = 1'b1;
                    stop     = 1'b1;
                end else begin
                    cp = {cp[CP_W-7:0], cont[5:0] & BITS_CONT[5:0]};
                end
            end
        end
        if (r.broken) begin
            r.cp  = {13'd0, lead};
            r.len = 3'd1;
        end else begin
            r.cp  = cp;
            r.len = need;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lu8d_ctrl.sv */
// Controller state machine of the lenient UTF-8 decoder.
// Depends on lu8d_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module lu8d_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lu8d_pkg::status_t status,
    output lu8d_pkg::cmd_t         cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    logic   tready_reg;

    always_comb begin
        cmd.load = s_tvalid && tready_reg;
        cmd.step = (state_reg == ST_EVAL) && status.out_free;
    end

    assign s_tready = tready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && tready_reg) begin
                        state_reg  <= ST_EVAL;
                        tready_reg <= 1'b0;
                    end
                end
                ST_EVAL: begin
                    if (status.out_free && (status.waiting || status.last)) begin
                        state_reg  <= ST_IDLE;
                        tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg  <= ST_IDLE;
                    tready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lu8d_dpath.sv */
// Datapath of the lenient UTF-8 decoder: byte queue, segment decode and
// the result register. Depends on lu8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lu8d_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire lu8d_pkg::cmd_t    cmd,
    output lu8d_pkg::status_t      status,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser
);

    logic [lu8d_pkg::QUEUE_W-1:0] q_reg;
    logic [lu8d_pkg::QUEUE_W-1:0] q_next;
    logic [lu8d_pkg::QUEUE_W-1:0] q_shift;
    logic [2:0]                   cnt_reg;
    logic [2:0]                   cnt_next;
    logic [2:0]                   rem;
    logic                         eot_reg;
    logic                         valid_reg;
    logic [lu8d_pkg::CP_W-1:0]    cp_reg;
    logic [2:0]                   len_reg;
    logic                         fallback_reg;
    logic                         last_reg;
    logic                         done_reg;
    lu8d_pkg::seg_t               cur;
    lu8d_pkg::seg_t               nxt;
    logic                         last;
    logic                         emit;

    always_comb begin
        cur     = lu8d_pkg::seg_eval(q_reg, cnt_reg, eot_reg);
        rem     = cnt_reg - cur.len;
        q_shift = q_reg >> {cur.len, 3'b000};
        nxt     = lu8d_pkg::seg_eval(q_shift, rem, eot_reg);
        last    = (rem == 3'd0) || nxt.waiting;
        emit    = cmd.step && !cur.waiting;
    end

    always_comb begin
        status.out_free = !valid_reg || m_tready;
        status.waiting  = cur.waiting;
        status.last     = last;
    end

    always_comb begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            q_next[{cnt_reg[1:0], 3'b000} +: 8] = s_tdata;
            cnt_next = cnt_reg + 3'd1;
        end else if (emit) begin
            q_next   = q_shift;
            cnt_next = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        if (cmd.load) begin
            eot_reg <= s_tlast;
        end
        if (emit) begin
            cp_reg       <= cur.cp;
            len_reg      <= cur.len;
            fallback_reg <= cur.broken;
            last_reg     <= last;
            done_reg     <= last && eot_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {len_reg, cp_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = {done_reg, fallback_reg};

endmodule

`default_nettype wire

/* rtl/core/lenient_utf8_decoder_top.sv */
// Top level of the lenient UTF-8 decoder: controller and datapath joined.
// Depends on lu8d_pkg, lu8d_ctrl and lu8d_dpath.
// The first result of a beat is registered once the controller has moved to its
// evaluate state and the output register is free. A new beat is not taken until
// the results of the last one are decoded; the datapath decodes one sequence per
// cycle from the held byte queue while the output register is free.
// Reset clears the controller, the held byte count and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module lenient_utf8_decoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // code_point[20:0], bytes_taken[23:21]
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // is_fallback[0], text_done[1]
);

    lu8d_pkg::cmd_t    cmd;
    lu8d_pkg::status_t status;

    lu8d_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lu8d_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/lu8d_checker.sv */
// Port-level checks for the lenient UTF-8 decoder, bound to the top level.
// Depends on lenient_utf8_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module lu8d_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    // The end of the text always closes the run of results of its beat.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("text_done without last_of_run");

    // A fallback result is a single lead byte at or above 0x80.
    a_fallback_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[23:21] == 3'd1 && m_tdata[20:8] == 13'd0 && m_tdata[7]))
        else $error("malformed fallback result");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:21] != 3'd0 && m_tdata[23:21] <= 3'd4))
        else $error("bytes_taken out of range");

    // Each taken beat is decoded before the next one is taken.
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("beat taken while decoding");

endmodule

bind lenient_utf8_decoder_top lu8d_checker u_lu8d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
